// ===== rtl/ksel_pkg.sv =====
// ----------------------------------------------------------------------------
// ksel_pkg: shared types and constants for the k-th smallest selector
// Word layouts of the input, output and configuration channels, the cell
// control group and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ksel_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int ORDER_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_INDEX = 8'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } ksel_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] selected_value;
        logic                       rank_error;
        logic                       overflow;
    } ksel_out_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } ksel_cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SHIFT,
        ST_EMIT
    } ksel_state_t;

endpackage

// ===== rtl/kth_smallest_select_unit.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_select_unit: order-statistic selector over a loaded sample set
// Selection: after a closing word the sequencer walks the chain down k
//   places in ST_SHIFT (k is 0 on a rank error), ends the walk, then emits.
// Throughput: one sample word per cycle while loading; input is held off
//   during the shift walk and the emit, longer while a result word waits.
// Reset: asynchronous active low; clears all cell valid bits, the count, the
//   overflow flag, the registers and out_valid at once. No clearing pass.
// ----------------------------------------------------------------------------
module kth_smallest_select_unit #(
    parameter int DEPTH = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ksel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ksel_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ksel_pkg::ksel_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ksel_pkg::ksel_out_t                out_data
);
    import ksel_pkg::*;

    // Count holds 0..DEPTH; rank register covers both a median rank and
    // the configured order index.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > ORDER_W) ? CW : ORDER_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ksel_state_t         state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [KW-1:0]       shift_reg, shift_next;
    logic                err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    ksel_out_t           out_data_reg, out_data_next;
    logic                median_reg;
    logic [ORDER_W-1:0]  order_reg;

    // ------------------------------------------------------------------
    // Cell chain: sorted ascending from cell 0, valid cells form a prefix
    // ------------------------------------------------------------------
    ksel_cell_ctrl_t            cell_ctrl;
    logic signed [SAMPLE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]           cell_valid;
    logic [DEPTH-1:0]           cell_lt;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [SAMPLE_W-1:0] prev_value;
            logic                       prev_valid;
            logic                       prev_lt;
            logic signed [SAMPLE_W-1:0] next_value;

            // Cell 0 has an always-valid, never-less neighbor below it;
            // the top cell keeps its own value on a shift.
            if (gi == 0)
            begin : g_first
                assign prev_value = in_data.sample;
                assign prev_valid = 1'b1;
                assign prev_lt    = 1'b0;
            end
            else
            begin : g_rest
                assign prev_value = cell_value[gi-1];
                assign prev_valid = cell_valid[gi-1];
                assign prev_lt    = cell_lt[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_top
                assign next_value = cell_value[gi];
            end
            else
            begin : g_mid
                assign next_value = cell_value[gi+1];
            end

            ksel_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .new_sample (in_data.sample),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_lt    (prev_lt),
                .next_value (next_value),
                .value      (cell_value[gi]),
                .valid      (cell_valid[gi]),
                .lt         (cell_lt[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Configuration: always ready, ungated; user must let writes land only while idle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg <= 1'b0;
            order_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MEDIAN_MODE: median_reg <= cfg_data[0];
                CFG_ORDER_INDEX: order_reg  <= cfg_data[ORDER_W-1:0];
                default:         ; // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic          in_fire;
    logic          chain_full;
    logic          do_insert;
    logic [CW-1:0] count_load;
    logic [KW-1:0] rank_k;
    logic          rank_bad;

    assign in_ready   = (state_reg == ST_LOAD);
    assign in_fire    = in_valid && in_ready;
    // Top cell valid means the buffer is full: drop and flag the sample
    assign chain_full = cell_valid[DEPTH-1];
    assign do_insert  = in_fire && !chain_full;
    assign count_load = count_reg + CW'(do_insert);

    always_comb
    begin
        if (median_reg)
        begin
            rank_k = KW'(count_load >> 1);
        end
        else
        begin
            rank_k = KW'(order_reg);
        end
        rank_bad = (rank_k >= KW'(count_load));
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        shift_next     = shift_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cell_ctrl      = '0;

        case (state_reg)
            ST_LOAD:
            begin
                cell_ctrl.insert = do_insert;
                if (in_fire)
                begin
                    count_next = count_load;
                    ovf_next   = ovf_reg | chain_full;
                    if (in_data.last_sample)
                    begin
                        // Closing word: the chain is sorted in the next cycle,
                        // then walk it down k places
                        err_next   = rank_bad;
                        shift_next = rank_bad ? '0 : rank_k;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (shift_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cell_ctrl.shift = 1'b1;
                    shift_next      = shift_reg - KW'(1);
                end
            end

            ST_EMIT:
            begin
                // Hold until the output register is free, then close the set
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.selected_value = err_reg ? '0 : cell_value[0];
                    out_data_next.rank_error     = err_reg;
                    out_data_next.overflow       = ovf_reg;
                    cell_ctrl.clear              = 1'b1;
                    count_next                   = '0;
                    ovf_next                     = 1'b0;
                    state_next                   = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            shift_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            shift_reg     <= shift_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("sample count past buffer depth");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with sample count");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (!out_valid_reg || out_ready)
        |=> (count_reg == '0) && (state_reg == ST_LOAD) && out_valid_reg)
        else $error("emit did not close the set");

    a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) && (shift_reg == '0) |=> (state_reg == ST_EMIT))
        else $error("shift walk did not end in emit");

endmodule

// ===== rtl/ksel_cell.sv =====
// ----------------------------------------------------------------------------
// ksel_cell: one slot of the sorted insertion chain
// Holds one sample and its valid bit. On insert, keep the value, take the
// new sample, or take the lower neighbor's value so the chain stays in
// ascending order. On shift, take the upper neighbor's value; clear drops the valid bit.
// ----------------------------------------------------------------------------
module ksel_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ksel_pkg::ksel_cell_ctrl_t           ctrl,
    input  logic signed [ksel_pkg::SAMPLE_W-1:0] new_sample,
    input  logic signed [ksel_pkg::SAMPLE_W-1:0] prev_value,
    input  logic                                prev_valid,
    input  logic                                prev_lt,
    input  logic signed [ksel_pkg::SAMPLE_W-1:0] next_value,
    output logic signed [ksel_pkg::SAMPLE_W-1:0] value,
    output logic                                valid,
    output logic                                lt
);
    import ksel_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       valid_reg;
    logic                       valid_next;

    // New sample belongs at or below this slot
    assign lt = !valid_reg || (new_sample < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (lt)
            begin
                value_next = prev_lt ? prev_value : new_sample;
                valid_next = valid_reg | prev_valid;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== tb/sv/kth_smallest_select_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kth_smallest_select_unit_tb: self-checking bench for the k-th smallest selector
// Loads signed sample sets through the input channel, closes each set with a
// last-marked word and checks every result word against a rank predictor kept
// in step with the accepted words and register writes. A short scripted pass
// covers extremes, both rank modes, rank errors and register masking. It is
// followed by randomized phases with varied idling, rank settings, duplicate
// heavy sets and a set that fills and overflows the buffer.
// ----------------------------------------------------------------------------
module kth_smallest_select_unit_tb;

    import ksel_pkg::*;

    localparam int DEPTH          = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 24;
    // Indexes past the two registers; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX    = 8'hFF;

    typedef enum logic
    {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    // One line of the scripted pass. A pinned row carries its result word
    // typed in; all other rows are scored by the predictor.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        ksel_in_t              word;
        bit                    pinned;
        ksel_out_t             want;
    } stim_row_t;

    // Block inputs, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    ksel_in_t              in_data   = '0;
    logic                  out_ready = 1'b0;

    logic                  cfg_ready;
    logic                  in_ready;
    logic                  out_valid;
    ksel_out_t             out_data;

    // Pinned result travelling alongside the input word it belongs to
    bit                    in_pin      = 1'b0;
    ksel_out_t             in_pin_word = '0;

    // Predictor state: the open set, its drop flag and the register copies
    int                    held_samples[$];
    bit                    dropped_seen = 1'b0;
    bit                    want_median  = 1'b0;
    logic [ORDER_W-1:0]    want_order   = '0;

    ksel_out_t             pending_results[$];
    stim_row_t             script[$];

    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    fail_count     = 0;
    int                    idle_cycles    = 0;

    ksel_out_t             predicted;
    ksel_out_t             oldest;

    kth_smallest_select_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: add one accepted word to the open set. On a closing word,
    // work out the result word and open a fresh set. The rank is found by
    // counting, for each candidate, how many members lie below it and how
    // many do not lie above it; the candidate whose span holds the rank is
    // the answer, duplicates included.
    // ------------------------------------------------------------------------
    function automatic bit select_on_close(input ksel_in_t w, output ksel_out_t res);
        int rank;
        int below;
        int not_above;
        res = '0;
        // Store while there is room; past the buffer depth, drop and flag
        if (held_samples.size() < DEPTH)
            held_samples.push_back(int'(w.sample));
        else
            dropped_seen = 1'b1;
        if (!w.last_sample)
            return 1'b0;
        rank = want_median ? (held_samples.size() >> 1) : int'(want_order);
        res.overflow = dropped_seen;
        if (rank >= held_samples.size())
        begin
            // Rank past the stored count: flag it, value stays zero
            res.rank_error = 1'b1;
        end
        else
        begin
            foreach (held_samples[i])
            begin
                below     = 0;
                not_above = 0;
                foreach (held_samples[j])
                begin
                    if (held_samples[j] < held_samples[i])
                        below++;
                    if (held_samples[j] <= held_samples[i])
                        not_above++;
                end
                if (below <= rank && rank < not_above)
                    res.selected_value = held_samples[i];
            end
        end
        held_samples.delete();
        dropped_seen = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: everything that happens at a rising edge is handled in this
    // one block, in a fixed order (check the result channel, then apply a
    // register write, then predict from an input word), so nothing depends
    // on how the simulator orders processes within the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, got %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (out_data.selected_value !== oldest.selected_value)
                    begin
                        $display("%0t: selected_value expected %0d, got %0d", $time,
                                 oldest.selected_value, out_data.selected_value);
                        fail_count++;
                    end
                    if (out_data.rank_error !== oldest.rank_error)
                    begin
                        $display("%0t: rank_error expected %b, got %b", $time,
                                 oldest.rank_error, out_data.rank_error);
                        fail_count++;
                    end
                    if (out_data.overflow !== oldest.overflow)
                    begin
                        $display("%0t: overflow expected %b, got %b", $time,
                                 oldest.overflow, out_data.overflow);
                        fail_count++;
                    end
                end
            end

            // Mirror register writes; mask to the register widths
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MEDIAN_MODE: want_median = cfg_data[0];
                    CFG_ORDER_INDEX: want_order  = cfg_data[ORDER_W-1:0];
                    default:         ;
                endcase
            end

            // A pinned row overrides the predicted word, the set still advances
            if (in_valid && in_ready)
            begin
                if (select_on_close(in_data, predicted))
                    pending_results.push_back(in_pin ? in_pin_word : predicted);
            end
        end
    end

    // Watchdog: end the run once no word has moved on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: stall at random, at the rate the current phase sets
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers. All inputs change at the falling edge. push_word returns at the
    // falling edge after acceptance with valid still high; the next action
    // either drives a new word or lowers valid in that same step.
    // ------------------------------------------------------------------------
    task automatic push_word(input ksel_in_t w, input bit pin, input ksel_out_t pin_word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        in_data     = w;
        in_pin      = pin;
        in_pin_word = pin_word;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Hold off until every expected result is out, then let the selection
    // walk's worth of cycles pass so the block is surely idle.
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DEPTH + 4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one complete set of n samples; the value style is drawn per set
    task automatic push_set(input int n);
        ksel_in_t w;
        int       style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                // narrow range: lots of duplicates around zero
                1:       w.sample = $signed(32'($urandom_range(0, 6))) - 32'sd3;
                // extremes mixed with neighbors and zero
                2:
                begin
                    case ($urandom_range(0, 4))
                        0:       w.sample = 32'sh7FFFFFFF;
                        1:       w.sample = 32'sh80000000;
                        2:       w.sample = 32'sh7FFFFFFE;
                        3:       w.sample = 32'sh80000001;
                        default: w.sample = 32'sd0;
                    endcase
                end
                default: w.sample = $urandom;
            endcase
            w.last_sample = (i == n - 1);
            push_word(w, 1'b0, '0);
        end
    endtask

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r        = '{kind: ROW_CFG, reg_index: idx, reg_value: val, word: '0,
                     pinned: 1'b0, want: '0};
        script.push_back(r);
    endfunction

    function automatic void add_word(input logic signed [SAMPLE_W-1:0] s, input bit last,
                                     input bit pin, input logic signed [SAMPLE_W-1:0] v,
                                     input bit err, input bit ovf);
        stim_row_t r;
        r        = '{kind: ROW_WORD, reg_index: '0, reg_value: '0,
                     word: '{sample: s, last_sample: last}, pinned: pin,
                     want: '{selected_value: v, rank_error: err, overflow: ovf}};
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int        sent;
        int        n;
        bit        median;
        logic [CFG_DATA_W-1:0] val;

        // Reset registers: rank 0, median off. Two single-member sets, then a pair.
        add_word(32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF, 1'b0, 1'b0);
        add_word(32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b0, 1'b0);
        add_word(32'sd0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b0, 1'b0);
        // Rank 2 of an unsorted set
        add_cfg(CFG_ORDER_INDEX, 8'd2);
        add_word(32'sd5, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd9, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(-32'sd3, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // Largest rank against a tiny set: rank error, value zero
        add_cfg(CFG_ORDER_INDEX, 8'hFF);
        add_word(32'sd1, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd2, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd3, 1'b1, 1'b1, 0, 1'b1, 1'b0);
        // Median mode: even count picks the upper median
        add_cfg(CFG_MEDIAN_MODE, 8'd1);
        add_word(32'sd10, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(-32'sd10, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd3, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        add_word(-32'sd1, 1'b1, 1'b1, -32'sd1, 1'b0, 1'b0);
        add_word(32'sd7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'sd7, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        // Writes past the register list do nothing; median bit is masked to bit 0
        add_cfg(CFG_UNUSED_INDEX, 8'h01);
        add_cfg(CFG_TOP_INDEX, 8'hFF);
        add_cfg(CFG_MEDIAN_MODE, 8'hFE);
        add_word(32'sd42, 1'b1, 1'b1, 0, 1'b1, 1'b0);
        // Alternating bit patterns at rank 0
        add_cfg(CFG_ORDER_INDEX, 8'd0);
        add_word(32'sh55555555, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_word(32'shAAAAAAAA, 1'b1, 1'b0, 0, 1'b0, 1'b0);

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the script
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
                write_reg(script[i].reg_index, script[i].reg_value);
            else
                push_word(script[i].word, script[i].pinned, script[i].want);
        end

        // Randomized phases, each with its own idling mix and rank setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            median = (phase % 3 == 1) && (phase != 10);
            // Upper bits of the median write are noise and must be masked off
            val    = 8'($urandom_range(0, 255));
            val[0] = median;
            write_reg(CFG_MEDIAN_MODE, val);
            if (phase == 10)
                val = 8'hFF;
            else if (phase == 6)
                val = 8'd0;
            else
                val = 8'($urandom_range(0, 9));
            write_reg(CFG_ORDER_INDEX, val);

            // Overflowing set at the top rank: the buffer fills, and the
            // closing word is itself dropped
            if (phase == 10)
                push_set(DEPTH + 1 + $urandom_range(0, 5));

            // Mostly short sets so the rank often lands inside, sometimes past
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                    n = $urandom_range(1, 12);
                else
                    n = $urandom_range(13, 40);
                push_set(n);
                sent += n;
            end
        end

        // Let every expected result arrive, then a selection walk's worth more
        drain_results();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
